// File: sv/dmc_pkg.sv
// ----------------------------------------------------------------------------
// Dinucleotide motif counter package
// Shared widths, register codes, reset values, result bundle and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

   localparam int MAX_LEN    = 256;
   localparam int NUM_MOTIFS = 5;
   localparam int NUM_PAIRS  = 5;
   localparam int NUM_SLOTS  = 2 * NUM_PAIRS;

   localparam int CHAR_W  = 8;
   localparam int PAIR_W  = 16;
   localparam int COUNT_W = 8;
   localparam int MOTIF_W = 3;
   localparam int SLOT_W  = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [COUNT_W-1:0] SAT_TOP =
      COUNT_W'(((MAX_LEN - 1) > 255) ? 255 : (MAX_LEN - 1));
   localparam logic [MOTIF_W-1:0] MOTIF_LIMIT =
      MOTIF_W'((NUM_MOTIFS < NUM_PAIRS) ? NUM_MOTIFS : NUM_PAIRS);

   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_ZERO  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_ONE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_TWO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_THREE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_FOUR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE      = 3'd5;

   localparam logic [NUM_PAIRS-1:0][PAIR_W-1:0] PAIR_RESET =
      {16'h4141, 16'h4743, 16'h5441, 16'h4354, 16'h4147};
   localparam logic [MOTIF_W-1:0] ACTIVE_RESET = 3'd5;

   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   typedef struct packed {
      logic [NUM_PAIRS-1:0][PAIR_W-1:0] pairs;
      logic [MOTIF_W-1:0]               active;
   } csr_type;

   // Slots 0 to 4 are match results, slots 5 to 9 are totals.
   typedef struct packed {
      logic [NUM_SLOTS-1:0]              pending;
      logic [NUM_PAIRS-1:0][COUNT_W-1:0] counts;
      logic [COUNT_W-1:0]                start;
   } bundle_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v >= SAT_TOP) ? SAT_TOP : COUNT_W'(v + 1'b1);
   endfunction

endpackage

`default_nettype wire

// File: sv/dmc_csr.sv
// ----------------------------------------------------------------------------
// Dinucleotide motif counter configuration registers
// Holds the five motif pairs and the active motif count.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [dmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dmc_pkg::PAIR_W-1:0]        csr_wdata,
   output dmc_pkg::csr_type                       csr
);

   dmc_pkg::csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pairs  <= dmc_pkg::PAIR_RESET;
         csr_ff.active <= dmc_pkg::ACTIVE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dmc_pkg::CSR_MOTIF_ZERO:  csr_ff.pairs[0] <= csr_wdata;
            dmc_pkg::CSR_MOTIF_ONE:   csr_ff.pairs[1] <= csr_wdata;
            dmc_pkg::CSR_MOTIF_TWO:   csr_ff.pairs[2] <= csr_wdata;
            dmc_pkg::CSR_MOTIF_THREE: csr_ff.pairs[3] <= csr_wdata;
            dmc_pkg::CSR_MOTIF_FOUR:  csr_ff.pairs[4] <= csr_wdata;
            dmc_pkg::CSR_ACTIVE:      csr_ff.active <= csr_wdata[dmc_pkg::MOTIF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

// File: sv/dmc_core.sv
// ----------------------------------------------------------------------------
// Dinucleotide motif counter core
// Input register, sequence state and the per-character match logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  dmc_pkg::csr_type                  csr,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [dmc_pkg::CHAR_W-1:0]   req_base_char,
   input  wire logic                         req_seq_start,
   input  wire logic                         req_seq_end,
   input  wire logic                         out_free,
   output logic                              bundle_load,
   output dmc_pkg::bundle_type               bundle
);

   localparam int NP = dmc_pkg::NUM_PAIRS;
   localparam int CW = dmc_pkg::COUNT_W;

   logic                         in_valid_ff;
   logic [dmc_pkg::CHAR_W-1:0]   in_char_ff;
   logic                         in_start_ff;
   logic                         in_end_ff;

   logic [dmc_pkg::CHAR_W-1:0]   prev_char_ff;
   logic                         prev_valid_ff;
   logic [CW-1:0]                position_ff;
   logic [NP-1:0][CW-1:0]        counts_ff;

   logic [dmc_pkg::MOTIF_W-1:0]  used;
   logic [NP-1:0]                enabled;
   logic                         eff_valid;
   logic [dmc_pkg::CHAR_W-1:0]   eff_char;
   logic [CW-1:0]                eff_pos;
   logic [NP-1:0][CW-1:0]        eff_counts;
   logic [NP-1:0]                hit;
   logic [NP-1:0][CW-1:0]        new_counts;
   logic [CW-1:0]                pos_in;
   logic                         has_results;
   logic                         advance;

   always_comb begin
      used = (csr.active < dmc_pkg::MOTIF_LIMIT) ? csr.active : dmc_pkg::MOTIF_LIMIT;
      eff_valid  = in_start_ff ? 1'b0 : prev_valid_ff;
      eff_char   = in_start_ff ? '0 : prev_char_ff;
      eff_pos    = in_start_ff ? '0 : position_ff;
      eff_counts = in_start_ff ? '0 : counts_ff;
      for (int i = 0; i < NP; i++) begin
         enabled[i] = dmc_pkg::MOTIF_W'(i) < used;
         hit[i] = enabled[i] && eff_valid
                  && (eff_char == csr.pairs[i][15:8])
                  && (in_char_ff == csr.pairs[i][7:0]);
         new_counts[i] = hit[i] ? dmc_pkg::sat_inc(eff_counts[i]) : eff_counts[i];
      end
      pos_in = eff_valid ? dmc_pkg::sat_inc(eff_pos) : '0;
      bundle.pending = {(in_end_ff ? enabled : {NP{1'b0}}), hit};
      bundle.counts  = new_counts;
      bundle.start   = eff_pos;
   end

   assign has_results = |bundle.pending;
   assign advance     = in_valid_ff && (!has_results || out_free);
   assign bundle_load = advance && has_results;
   assign req_ready   = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_base_char;
         in_start_ff <= req_seq_start;
         in_end_ff   <= req_seq_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_char_ff  <= '0;
         prev_valid_ff <= 1'b0;
         position_ff   <= '0;
         counts_ff     <= '0;
      end else if (advance) begin
         if (in_end_ff) begin
            prev_char_ff  <= '0;
            prev_valid_ff <= 1'b0;
            position_ff   <= '0;
            counts_ff     <= '0;
         end else begin
            prev_char_ff  <= in_char_ff;
            prev_valid_ff <= 1'b1;
            position_ff   <= pos_in;
            counts_ff     <= new_counts;
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/dmc_out.sv
// ----------------------------------------------------------------------------
// Dinucleotide motif counter result serializer
// Holds one item's results and sends them in slot order, one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_out (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          bundle_load,
   input  dmc_pkg::bundle_type                bundle,
   output logic                               out_free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_kind,
   output logic [dmc_pkg::MOTIF_W-1:0]        rsp_motif_number,
   output logic [dmc_pkg::COUNT_W-1:0]        rsp_start_index,
   output logic [dmc_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic                               rsp_final_result
);

   localparam int NS = dmc_pkg::NUM_SLOTS;
   localparam int NP = dmc_pkg::NUM_PAIRS;

   logic [NS-1:0]                          pending_ff;
   logic [NP-1:0][dmc_pkg::COUNT_W-1:0]    counts_ff;
   logic [dmc_pkg::COUNT_W-1:0]            start_ff;

   logic [dmc_pkg::SLOT_W-1:0]             sel;
   logic [NS-1:0]                          rest;
   logic [dmc_pkg::MOTIF_W-1:0]            motif;
   logic                                   take;

   always_comb begin
      sel = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            sel = dmc_pkg::SLOT_W'(i);
         end
      end
      rest = pending_ff & ~(NS'(1) << sel);
      rsp_kind = (sel >= dmc_pkg::SLOT_W'(NP)) ? dmc_pkg::KIND_TOTAL : dmc_pkg::KIND_MATCH;
      motif = (rsp_kind == dmc_pkg::KIND_TOTAL)
              ? dmc_pkg::MOTIF_W'(sel - dmc_pkg::SLOT_W'(NP))
              : dmc_pkg::MOTIF_W'(sel);
   end

   assign rsp_valid        = |pending_ff;
   assign rsp_final_result = (rest == '0);
   assign rsp_motif_number = motif;
   assign rsp_start_index  = (rsp_kind == dmc_pkg::KIND_TOTAL) ? '0 : start_ff;
   assign rsp_match_count  = counts_ff[motif];
   assign take             = rsp_valid && rsp_ready;
   assign out_free         = !rsp_valid || (take && rsp_final_result);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (bundle_load) begin
         pending_ff <= bundle.pending;
      end else if (take) begin
         pending_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         counts_ff <= bundle.counts;
         start_ff  <= bundle.start;
      end
   end

endmodule

`default_nettype wire

// File: sv/dinucleotide_motif_counter.sv
// ----------------------------------------------------------------------------
// Dinucleotide motif counter
// Counts two-letter motifs in a character stream and reports each match and
// the per-motif totals at the end of a sequence.
//
// The request channel takes one character per cycle while req_ready is high,
// with seq_start and seq_end flags. The response channel carries one result
// per transfer: match events in stream order, then totals after the last
// character, with final_result set on the last result caused by a request.
// An accepted request waits in the core's input register; its results are
// then loaded into the serializer, which drives the response ports.
// Requests flow at one per cycle while each causes at most one result and
// rsp_ready is high; a request with more results holds the response channel
// until all are taken, as the serializer sends one result per cycle while
// rsp_ready is high. When the receiver stalls, a request with results waits
// in the input register while the held results wait; then req_ready drops.
// Reset restores the default motifs and active count and clears the sequence
// state and any pending results. Configuration is written through csr_we,
// csr_index and csr_wdata; the user does so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module dinucleotide_motif_counter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dmc_pkg::CHAR_W-1:0]    req_base_char,
   input  wire logic                          req_seq_start,
   input  wire logic                          req_seq_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_kind,
   output logic [dmc_pkg::MOTIF_W-1:0]        rsp_motif_number,
   output logic [dmc_pkg::COUNT_W-1:0]        rsp_start_index,
   output logic [dmc_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic                               rsp_final_result,
   input  wire logic                          csr_we,
   input  wire logic [dmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dmc_pkg::PAIR_W-1:0]    csr_wdata
);

   dmc_pkg::csr_type    csr;
   dmc_pkg::bundle_type bundle;
   logic                bundle_load;
   logic                out_free;

   dmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   dmc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_base_char (req_base_char),
      .req_seq_start (req_seq_start),
      .req_seq_end   (req_seq_end),
      .out_free      (out_free),
      .bundle_load   (bundle_load),
      .bundle        (bundle)
   );

   dmc_out u_out (
      .clock            (clock),
      .reset            (reset),
      .bundle_load      (bundle_load),
      .bundle           (bundle),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_motif_number (rsp_motif_number),
      .rsp_start_index  (rsp_start_index),
      .rsp_match_count  (rsp_match_count),
      .rsp_final_result (rsp_final_result)
   );

endmodule

`default_nettype wire

// File: tb/motif_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motif counter scoreboard
// Tracks the motif registers and the sequence state of the counter, turns
// every accepted request into the match and total results it must produce,
// and checks the results that come back against them in order.
// ----------------------------------------------------------------------------

package motif_scoreboard_pkg;

   import dmc_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [MOTIF_W-1:0] motif;
      logic [COUNT_W-1:0] start_index;
      logic [COUNT_W-1:0] match_count;
      logic               final_flag;
   } motif_result_type;

   class motif_scoreboard;

      logic [PAIR_W-1:0]  motif_pairs [NUM_PAIRS];
      logic [MOTIF_W-1:0] active_count;
      logic [CHAR_W-1:0]  prev_char;
      bit                 prev_valid;
      logic [COUNT_W-1:0] position;
      logic [COUNT_W-1:0] match_counts [NUM_PAIRS];
      motif_result_type   expected_results [$];
      int                 mismatches;

      function new();
         for (int i = 0; i < NUM_PAIRS; i++) begin
            motif_pairs[i] = PAIR_RESET[i];
         end
         active_count = ACTIVE_RESET;
         mismatches = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         prev_char = '0;
         prev_valid = 1'b0;
         position = '0;
         for (int i = 0; i < NUM_PAIRS; i++) begin
            match_counts[i] = '0;
         end
      endfunction

      function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
         return (v >= SAT_TOP) ? SAT_TOP : COUNT_W'(v + 1);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [PAIR_W-1:0] data);
         if (index < NUM_PAIRS) begin
            motif_pairs[index] = data;
         end else if (index == CSR_ACTIVE) begin
            active_count = data[MOTIF_W-1:0];
         end
      endfunction

      function void note_request(logic [CHAR_W-1:0] ch, logic seq_start, logic seq_end);
         int used;
         motif_result_type r;
         motif_result_type burst [$];
         used = int'((active_count < MOTIF_LIMIT) ? active_count : MOTIF_LIMIT);
         if (seq_start) begin
            clear_sequence();
         end
         if (prev_valid) begin
            for (int i = 0; i < used; i++) begin
               if (prev_char == motif_pairs[i][15:8] && ch == motif_pairs[i][7:0]) begin
                  match_counts[i] = bump(match_counts[i]);
                  r.kind = KIND_MATCH;
                  r.motif = MOTIF_W'(i);
                  r.start_index = position;
                  r.match_count = match_counts[i];
                  r.final_flag = 1'b0;
                  burst.push_back(r);
               end
            end
            position = bump(position);
         end else begin
            position = '0;
         end
         prev_char = ch;
         prev_valid = 1'b1;
         if (seq_end) begin
            for (int i = 0; i < used; i++) begin
               r.kind = KIND_TOTAL;
               r.motif = MOTIF_W'(i);
               r.start_index = '0;
               r.match_count = match_counts[i];
               r.final_flag = 1'b0;
               burst.push_back(r);
            end
            clear_sequence();
         end
         if (burst.size() > 0) begin
            burst[burst.size() - 1].final_flag = 1'b1;
         end
         foreach (burst[k]) begin
            expected_results.push_back(burst[k]);
         end
      endfunction

      function void check_result(motif_result_type got);
         motif_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: kind=%0d motif=%0d start=%0d count=%0d final=%0d",
                        got.kind, got.motif, got.start_index, got.match_count,
                        got.final_flag);
            end
            return;
         end
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.motif !== want.motif ||
             got.start_index !== want.start_index ||
             got.match_count !== want.match_count ||
             got.final_flag !== want.final_flag) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result differs: expected kind=%0d motif=%0d start=%0d count=%0d final=%0d",
                        want.kind, want.motif, want.start_index, want.match_count,
                        want.final_flag);
               $display("          got kind=%0d motif=%0d start=%0d count=%0d final=%0d",
                        got.kind, got.motif, got.start_index, got.match_count,
                        got.final_flag);
            end
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

   endclass

endpackage

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dinucleotide motif counter testbench
// Streams directed and random DNA-like sequences into the counter under
// several motif settings, with random idling on both channels, and checks
// every match and total against a scoreboard that predicts them.
// ----------------------------------------------------------------------------

module testbench;

   import dmc_pkg::*;
   import motif_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_base_char;
   logic                 req_seq_start;
   logic                 req_seq_end;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_kind;
   logic [MOTIF_W-1:0]   rsp_motif_number;
   logic [COUNT_W-1:0]   rsp_start_index;
   logic [COUNT_W-1:0]   rsp_match_count;
   logic                 rsp_final_result;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PAIR_W-1:0]    csr_wdata;

   motif_scoreboard   sb;
   logic [PAIR_W-1:0] cur_pairs [NUM_PAIRS];
   logic [PAIR_W-1:0] new_pairs [NUM_PAIRS];
   logic [CHAR_W-1:0] acgt [4] = '{"A", "C", "G", "T"};
   bit                tx_quiet;
   bit                rx_quiet;
   int                cycle_count;
   motif_result_type  seen;

   dinucleotide_motif_counter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_base_char    (req_base_char),
      .req_seq_start    (req_seq_start),
      .req_seq_end      (req_seq_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_motif_number (rsp_motif_number),
      .rsp_start_index  (rsp_start_index),
      .rsp_match_count  (rsp_match_count),
      .rsp_final_result (rsp_final_result),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = rx_quiet || ($urandom_range(99) >= 19);
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("dinucleotide_motif_counter: mismatch");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind = rsp_kind;
         seen.motif = rsp_motif_number;
         seen.start_index = rsp_start_index;
         seen.match_count = rsp_match_count;
         seen.final_flag = rsp_final_result;
         sb.check_result(seen);
      end
   end

   task automatic send_request(input logic [CHAR_W-1:0] ch, input logic s, input logic e);
      while (!tx_quiet && $urandom_range(99) < 19) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_base_char = ch;
      req_seq_start = s;
      req_seq_end = e;
      do @(posedge clock); while (!req_ready);
      sb.note_request(ch, s, e);
      @(negedge clock);
   endtask

   task automatic send_text(input string text, input logic s, input logic e);
      for (int i = 0; i < text.len(); i++) begin
         send_request(text[i], s && (i == 0), e && (i == text.len() - 1));
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [PAIR_W-1:0] data);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = data;
      sb.write_reg(index, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [PAIR_W-1:0] pairs [NUM_PAIRS],
                            input logic [MOTIF_W-1:0] active);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      for (int i = 0; i < NUM_PAIRS; i++) begin
         csr_write(CSR_MOTIF_ZERO + CSR_IDX_W'(i), pairs[i]);
         cur_pairs[i] = pairs[i];
      end
      csr_write(CSR_ACTIVE, {13'($urandom), active});
      csr_write($urandom_range(1) ? CSR_UNUSED_HI : CSR_UNUSED_LO, 16'($urandom));
      csr_we = 1'b0;
   endtask

   task automatic random_sequences(input int n_items, input int min_len, input int max_len,
                                   input int quiet_items, input int foreign_pct,
                                   input int noise_pct);
      int sent;
      int len;
      int pick;
      logic [CHAR_W-1:0] ch;
      logic s;
      logic e;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(max_len, min_len);
         for (int k = 0; k < len && sent < n_items; k++) begin
            tx_quiet = (sent < quiet_items);
            rx_quiet = tx_quiet;
            pick = $urandom_range(2 * NUM_PAIRS - 1);
            if ($urandom_range(99) < foreign_pct) begin
               ch = CHAR_W'($urandom);
            end else begin
               ch = cur_pairs[pick / 2][(pick % 2) * 8 +: 8];
            end
            s = (k == 0);
            e = (k == len - 1);
            if ($urandom_range(99) < noise_pct) begin
               s = 1'($urandom_range(1));
               e = 1'($urandom_range(1));
            end
            if (sent == 5 || $urandom_range(99) < 2) begin
               while (sb.pending() != 0) begin
                  req_valid = 1'b0;
                  @(negedge clock);
               end
            end
            send_request(ch, s, e);
            sent++;
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_base_char = '0;
      req_seq_start = 1'b0;
      req_seq_end = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      for (int i = 0; i < NUM_PAIRS; i++) begin
         cur_pairs[i] = PAIR_RESET[i];
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_text("AGCTAAGC", 1'b1, 1'b1);
      send_text("A", 1'b1, 1'b1);
      send_text("AA", 1'b1, 1'b0);
      send_request("G", 1'b1, 1'b1);
      send_text("AG", 1'b0, 1'b1);
      send_text("AA", 1'b1, 1'b0);
      send_request("A", 1'b1, 1'b0);
      send_text("AG", 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request("A", 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1);

      configure('{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0000}, 3'd7);
      random_sequences(50, 1, 8, 0, 10, 8);

      for (int i = 0; i < NUM_PAIRS; i++) begin
         new_pairs[i] = {acgt[$urandom_range(3)], acgt[$urandom_range(3)]};
      end
      configure(new_pairs, 3'd0);
      random_sequences(20, 1, 6, 0, 20, 10);

      configure('{16'h4141, 16'h4141, 16'h4141, 16'h4141, 16'h4141}, 3'd5);
      random_sequences(260, 260, 260, 150, 2, 0);

      for (int i = 0; i < NUM_PAIRS; i++) begin
         new_pairs[i] = {acgt[$urandom_range(3)], acgt[$urandom_range(3)]};
      end
      configure(new_pairs, MOTIF_W'($urandom_range(4, 1)));
      random_sequences(40, 1, 10, 0, 10, 8);

      for (int i = 0; i < NUM_PAIRS; i++) begin
         new_pairs[i] = PAIR_W'($urandom);
      end
      configure(new_pairs, MOTIF_W'($urandom_range(6, 5)));
      random_sequences(30, 1, 6, 0, 15, 8);

      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("dinucleotide_motif_counter: match");
      end else begin
         $display("dinucleotide_motif_counter: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
sv/dmc_pkg.sv
sv/dmc_csr.sv
sv/dmc_core.sv
sv/dmc_out.sv
sv/dinucleotide_motif_counter.sv
tb/motif_scoreboard_pkg.sv
tb/testbench.sv
